// ----- src/lbg_pkg.sv -----
// Shared constants, codes and control types for the LED bar graph renderer.
package lbg_pkg;

   // Fixed levels and strip limits.
   localparam int MAX_LEDS      = 64;
   localparam int NEUTRAL_LEVEL = 1500;
   localparam int FULL_LEVEL    = 2000;
   localparam int SPAN          = (FULL_LEVEL > NEUTRAL_LEVEL) ? (FULL_LEVEL - NEUTRAL_LEVEL) : 0;

   // Field widths.
   localparam int SAMPLE_W = 12;
   localparam int COUNT_W  = 7;
   localparam int IDX_W    = 6;
   localparam int MODE_W   = 2;
   localparam int COLOR_W  = 24;
   localparam int CHAN_W   = 8;
   localparam int TAG_W    = 3;
   localparam int CSR_IDX_W = 2;

   // Divider geometry: a 20-bit numerator over a 12-bit divisor.
   localparam int DIV_NUM_W = 20;
   localparam int DIV_DEN_W = 12;
   localparam int DIV_CNT_W = 5;

   localparam logic [SAMPLE_W-1:0]  NEUTRAL_VAL = SAMPLE_W'(NEUTRAL_LEVEL);
   localparam logic [DIV_DEN_W-1:0] SPAN_VAL    = DIV_DEN_W'(SPAN);
   localparam logic [COUNT_W-1:0]   MAX_COUNT   = COUNT_W'(MAX_LEDS);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_COLOR = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_COLOR    = 2'd3;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] LED_COUNT_RST      = 7'd8;
   localparam logic [MODE_W-1:0]  FILL_MODE_RST      = 2'd2;
   localparam logic [COLOR_W-1:0] THROTTLE_COLOR_RST = 24'h00FF00;
   localparam logic [COLOR_W-1:0] BRAKE_COLOR_RST    = 24'hFF0000;

   // Fill modes; the unused code behaves as middle mode.
   localparam logic [MODE_W-1:0] MODE_TOP    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BOTTOM = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MIDDLE = 2'd2;

   // Divider operand selection.
   localparam logic [1:0] DIV_STEP = 2'd0;
   localparam logic [1:0] DIV_FULL = 2'd1;
   localparam logic [1:0] DIV_PART = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       div_go;
      logic [1:0] div_sel;
      logic       cap_step;
      logic       cap_full;
      logic       cap_part;
      logic       prep;
      logic       emit;
   } lbg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
      logic last_idx;
   } lbg_status_type;

endpackage

// ----- src/lbg_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module lbg_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lbg_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [lbg_pkg::DIV_DEN_W-1:0]  divisor,
   input  logic [lbg_pkg::DIV_CNT_W-1:0]  iters,
   output logic [lbg_pkg::DIV_NUM_W-1:0]  quotient,
   output logic [lbg_pkg::DIV_DEN_W-1:0]  remainder,
   output logic                           done
);
   import lbg_pkg::*;

   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DIV_DEN_W:0]   partial;
   logic [DIV_DEN_W:0]   diff;
   logic                 ge;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign partial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign diff    = partial - {1'b0, divisor};
   assign ge      = (partial >= {1'b0, divisor});

   // The numerator shifts out at the top while quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= dividend;
            rem_ff  <= '0;
            cnt_ff  <= iters;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff <= {num_ff[DIV_NUM_W-2:0], ge};
            rem_ff <= ge ? diff[DIV_DEN_W-1:0] : partial[DIV_DEN_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient  = num_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

// ----- src/lbg_datapath.sv -----
// Datapath: configuration registers, item registers, divider operands and LED colouring.
module lbg_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lbg_pkg::lbg_cmd_type              cmd,
   output lbg_pkg::lbg_status_type           status,
   input  logic                              csr_we,
   input  logic [lbg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lbg_pkg::COLOR_W-1:0]       csr_wdata,
   input  logic [lbg_pkg::SAMPLE_W-1:0]      req_throttle_sample,
   input  logic                              req_strip_enabled,
   input  logic                              req_animation_enabled,
   input  logic [lbg_pkg::TAG_W-1:0]         req_strip_id,
   output logic                              rsp_strobe,
   output logic [lbg_pkg::TAG_W-1:0]         rsp_strip_tag,
   output logic [lbg_pkg::IDX_W-1:0]         rsp_led_index,
   output logic [lbg_pkg::CHAN_W-1:0]        rsp_red,
   output logic [lbg_pkg::CHAN_W-1:0]        rsp_green,
   output logic [lbg_pkg::CHAN_W-1:0]        rsp_blue,
   output logic                              rsp_last_led
);
   import lbg_pkg::*;

   // Configuration registers.
   logic [COUNT_W-1:0] led_count_ff;
   logic [MODE_W-1:0]  fill_mode_ff;
   logic [COLOR_W-1:0] throttle_color_ff;
   logic [COLOR_W-1:0] brake_color_ff;

   // Registers of the request being rendered.
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic                 on_ff;
   logic [SAMPLE_W-1:0]  dist_ff, dist_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic [DIV_DEN_W-1:0] step_ff, step_in;
   logic [DIV_DEN_W-1:0] full_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [CHAN_W-1:0]    part_ff;
   logic [COLOR_W-1:0]   dim_ff, dim_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   // Result registers.
   logic                 rsp_strobe_ff;
   logic [TAG_W-1:0]     rsp_tag_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic [COLOR_W-1:0]   rsp_color_ff;
   logic                 rsp_last_ff;

   // Divider connections.
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_CNT_W-1:0] div_iters;
   logic [DIV_NUM_W-1:0] div_quot;
   logic [DIV_DEN_W-1:0] div_rem;
   logic                 div_done;

   logic                 braking;
   logic [CHAN_W:0]      part_plus;
   logic [16:0]          prod_r, prod_g, prod_b;
   logic [COUNT_W-1:0]   idx_ext;
   logic [COUNT_W-1:0]   half;
   logic [COUNT_W-1:0]   pos;
   logic [DIV_DEN_W-1:0] pos_ext;
   logic [COLOR_W-1:0]   lit_color;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         led_count_ff      <= LED_COUNT_RST;
         fill_mode_ff      <= FILL_MODE_RST;
         throttle_color_ff <= THROTTLE_COLOR_RST;
         brake_color_ff    <= BRAKE_COLOR_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LED_COUNT:      led_count_ff      <= csr_wdata[COUNT_W-1:0];
            CSR_FILL_MODE:      fill_mode_ff      <= csr_wdata[MODE_W-1:0];
            CSR_THROTTLE_COLOR: throttle_color_ff <= csr_wdata;
            CSR_BRAKE_COLOR:    brake_color_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request capture: clamp the count, pick the colour and take the distance from neutral.
   always_comb begin
      if (led_count_ff == '0) begin
         count_in = COUNT_W'(1);
      end else if (led_count_ff > MAX_COUNT) begin
         count_in = MAX_COUNT;
      end else begin
         count_in = led_count_ff;
      end
      braking  = (req_throttle_sample < NEUTRAL_VAL);
      dist_in  = braking ? (NEUTRAL_VAL - req_throttle_sample)
                         : (req_throttle_sample - NEUTRAL_VAL);
      color_in = braking ? brake_color_ff : throttle_color_ff;
   end

   // Divider operands for the three divisions of one request.
   always_comb begin
      case (cmd.div_sel)
         DIV_STEP: begin
            div_num   = {SPAN_VAL, 8'd0};
            div_den   = {{(DIV_DEN_W-COUNT_W){1'b0}}, count_ff};
            div_iters = DIV_CNT_W'(DIV_DEN_W);
         end
         DIV_FULL: begin
            div_num   = {dist_ff, 8'd0};
            div_den   = step_ff;
            div_iters = DIV_CNT_W'(SAMPLE_W);
         end
         DIV_PART: begin
            // 255 * remainder as a shift and a subtract.
            div_num   = {rem_ff, 8'd0} - {8'd0, rem_ff};
            div_den   = step_ff;
            div_iters = DIV_CNT_W'(DIV_NUM_W);
         end
         default: begin
            div_num   = '0;
            div_den   = '0;
            div_iters = '0;
         end
      endcase
   end

   lbg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_go),
      .dividend  (div_num),
      .divisor   (div_den),
      .iters     (div_iters),
      .quotient  (div_quot),
      .remainder (div_rem),
      .done      (div_done)
   );

   // A step of zero is taken as one.
   assign step_in = (div_quot[DIV_DEN_W-1:0] == '0) ? DIV_DEN_W'(1) : div_quot[DIV_DEN_W-1:0];

   // Partly lit colour, each channel scaled by (part + 1) / 256.
   assign part_plus = {1'b0, part_ff} + 9'd1;
   assign prod_r    = 17'(color_ff[23:16]) * 17'(part_plus);
   assign prod_g    = 17'(color_ff[15:8])  * 17'(part_plus);
   assign prod_b    = 17'(color_ff[7:0])   * 17'(part_plus);
   assign dim_in    = {prod_r[15:8], prod_g[15:8], prod_b[15:8]};

   // Fill position of the current LED and its colour.
   always_comb begin
      idx_ext = {1'b0, idx_ff};
      half    = count_ff >> 1;
      case (mode_ff)
         MODE_TOP:    pos = count_ff - COUNT_W'(1) - idx_ext;
         MODE_BOTTOM: pos = idx_ext;
         default:     pos = (idx_ext < half) ? (half - COUNT_W'(1) - idx_ext) : (idx_ext - half);
      endcase
      pos_ext = {{(DIV_DEN_W-COUNT_W){1'b0}}, pos};
      if (!on_ff) begin
         lit_color = '0;
      end else if (pos_ext < full_ff) begin
         lit_color = color_ff;
      end else if (pos_ext == full_ff) begin
         lit_color = dim_ff;
      end else begin
         lit_color = '0;
      end
   end

   assign idx_in = cmd.prep ? '0 : (idx_ff + 1'b1);

   // Item registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         count_ff <= count_in;
         mode_ff  <= fill_mode_ff;
         tag_ff   <= req_strip_id;
         on_ff    <= req_strip_enabled & req_animation_enabled;
         dist_ff  <= dist_in;
         color_ff <= color_in;
      end
      if (cmd.cap_step) begin
         step_ff <= step_in;
      end
      if (cmd.cap_full) begin
         full_ff <= div_quot[DIV_DEN_W-1:0];
         rem_ff  <= div_rem;
      end
      if (cmd.cap_part) begin
         part_ff <= div_quot[CHAN_W-1:0];
      end
      if (cmd.prep) begin
         dim_ff <= dim_in;
      end
      if (cmd.prep || cmd.emit) begin
         idx_ff <= idx_in;
      end
   end

   // Result registers; the strobe lasts one cycle per LED.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tag_ff   <= tag_ff;
         rsp_idx_ff   <= idx_ff;
         rsp_color_ff <= lit_color;
         rsp_last_ff  <= status.last_idx;
      end
   end

   assign status.div_done = div_done;
   assign status.last_idx = (idx_ext == (count_ff - COUNT_W'(1)));

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_strip_tag = rsp_tag_ff;
   assign rsp_led_index = rsp_idx_ff;
   assign rsp_red       = rsp_color_ff[23:16];
   assign rsp_green     = rsp_color_ff[15:8];
   assign rsp_blue      = rsp_color_ff[7:0];
   assign rsp_last_led  = rsp_strobe_ff & rsp_last_ff;

   // A result only follows an emit command.
   a_strobe_after_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.emit))
      else $error("result strobe without an emit command");

   // Within a frame the LED index advances by one on every result.
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_last_ff) |=>
         (rsp_strobe_ff && (rsp_idx_ff == IDX_W'($past(rsp_idx_ff) + 1'b1))))
      else $error("LED results of a frame are not contiguous");

   // The divider is never restarted in the cycle its result is collected.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.div_go |-> !div_done)
      else $error("divider started while a result was pending");

endmodule

// ----- src/lbg_ctrl.sv -----
// Controller state machine sequencing the divisions and the LED results of a request.
module lbg_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   output lbg_pkg::lbg_cmd_type     cmd,
   input  lbg_pkg::lbg_status_type  status
);
   import lbg_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_STEP_GO   = 4'd1;
   localparam logic [3:0] S_STEP_WAIT = 4'd2;
   localparam logic [3:0] S_FULL_GO   = 4'd3;
   localparam logic [3:0] S_FULL_WAIT = 4'd4;
   localparam logic [3:0] S_PART_GO   = 4'd5;
   localparam logic [3:0] S_PART_WAIT = 4'd6;
   localparam logic [3:0] S_PREP      = 4'd7;
   localparam logic [3:0] S_EMIT      = 4'd8;

   logic [3:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_STEP_GO;
            end
         end
         S_STEP_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_STEP;
            state_in    = S_STEP_WAIT;
         end
         S_STEP_WAIT: begin
            if (status.div_done) begin
               cmd.cap_step = 1'b1;
               state_in     = S_FULL_GO;
            end
         end
         S_FULL_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_FULL;
            state_in    = S_FULL_WAIT;
         end
         S_FULL_WAIT: begin
            cmd.div_sel = DIV_FULL;
            if (status.div_done) begin
               cmd.cap_full = 1'b1;
               state_in     = S_PART_GO;
            end
         end
         S_PART_GO: begin
            cmd.div_go  = 1'b1;
            cmd.div_sel = DIV_PART;
            state_in    = S_PART_WAIT;
         end
         S_PART_WAIT: begin
            cmd.div_sel = DIV_PART;
            if (status.div_done) begin
               cmd.cap_part = 1'b1;
               state_in     = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (status.last_idx) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   // The last LED of a frame returns the controller to idle.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.last_idx) |=> !busy)
      else $error("controller did not return to idle after the last LED");

   // A request is loaded only when the block is idle.
   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (start && !busy))
      else $error("request loaded while busy");

   // Emission follows the preparation cycle.
   a_emit_after_prep: assert property (@(posedge clock) disable iff (reset)
      $rose(cmd.emit) |-> $past(cmd.prep))
      else $error("LED emission began without preparation");

endmodule

// ----- src/led_bar_graph_renderer.sv -----
// Top level of the LED bar graph renderer: controller and datapath.
//
//  Channel   Ports                        Handshake
//  request   start, busy, req_*           taken when start is high and busy is low
//  result    rsp_strobe, rsp_*            one LED per strobe cycle, cannot be held off
//  config    csr_we, csr_index, csr_wdata written when csr_we is high
//
// A request runs three divisions on one shared bit-serial divider, then a step
// to scale the partial colour, then one LED result per cycle. busy falls after
// the last LED, so a new request is taken only once the last one is done.
// Reset is synchronous and returns the configuration to its defaults.
// The result side has no back-pressure; results are registered and leave in the cycle after they are formed.
module led_bar_graph_renderer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lbg_pkg::SAMPLE_W-1:0]   req_throttle_sample,
   input  logic                           req_strip_enabled,
   input  logic                           req_animation_enabled,
   input  logic [lbg_pkg::TAG_W-1:0]      req_strip_id,
   output logic                           rsp_strobe,
   output logic [lbg_pkg::TAG_W-1:0]      rsp_strip_tag,
   output logic [lbg_pkg::IDX_W-1:0]      rsp_led_index,
   output logic [lbg_pkg::CHAN_W-1:0]     rsp_red,
   output logic [lbg_pkg::CHAN_W-1:0]     rsp_green,
   output logic [lbg_pkg::CHAN_W-1:0]     rsp_blue,
   output logic                           rsp_last_led,
   input  logic                           csr_we,
   input  logic [lbg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbg_pkg::COLOR_W-1:0]    csr_wdata
);
   import lbg_pkg::*;

   lbg_cmd_type    cmd;
   lbg_status_type status;

   // Sequencing.
   lbg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   // Arithmetic, configuration and results.
   lbg_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_throttle_sample   (req_throttle_sample),
      .req_strip_enabled     (req_strip_enabled),
      .req_animation_enabled (req_animation_enabled),
      .req_strip_id          (req_strip_id),
      .rsp_strobe            (rsp_strobe),
      .rsp_strip_tag         (rsp_strip_tag),
      .rsp_led_index         (rsp_led_index),
      .rsp_red               (rsp_red),
      .rsp_green             (rsp_green),
      .rsp_blue              (rsp_blue),
      .rsp_last_led          (rsp_last_led)
   );

endmodule

// ----- tb/sv/tb_led_bar_graph_renderer.sv -----
// Self-checking testbench for the LED bar graph renderer: directed and random requests.
module tb_led_bar_graph_renderer;
   import lbg_pkg::*;

   localparam int CLOCK_LIMIT  = 400000;
   localparam int PHASE_COUNT  = 10;
   localparam int PHASE_ITEMS  = 18;
   localparam int IDLE_PERCENT = 27;
   localparam int TAIL_CYCLES  = 120;

   // The fourth fill-mode code has no name in the package; it behaves as middle mode.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // One LED colour as it should leave the block.
   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [IDX_W-1:0]  index;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } led_colour_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [SAMPLE_W-1:0]  req_throttle_sample = '0;
   logic                 req_strip_enabled = 1'b0;
   logic                 req_animation_enabled = 1'b0;
   logic [TAG_W-1:0]     req_strip_id = '0;
   logic                 rsp_strobe;
   logic [TAG_W-1:0]     rsp_strip_tag;
   logic [IDX_W-1:0]     rsp_led_index;
   logic [CHAN_W-1:0]    rsp_red;
   logic [CHAN_W-1:0]    rsp_green;
   logic [CHAN_W-1:0]    rsp_blue;
   logic                 rsp_last_led;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COLOR_W-1:0]   csr_wdata = '0;

   // Shadow copy of the configuration registers.
   logic [COUNT_W-1:0] cfg_led_count = LED_COUNT_RST;
   logic [MODE_W-1:0]  cfg_fill_mode = FILL_MODE_RST;
   logic [COLOR_W-1:0] cfg_throttle  = THROTTLE_COLOR_RST;
   logic [COLOR_W-1:0] cfg_brake     = BRAKE_COLOR_RST;

   led_colour_type pending_leds[$];
   led_colour_type oldest_led;
   bit             idle_allowed = 1'b1;
   int             cycle_count = 0;
   int             requests_sent = 0;
   int             leds_checked = 0;
   int             error_count = 0;

   led_bar_graph_renderer dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_throttle_sample   (req_throttle_sample),
      .req_strip_enabled     (req_strip_enabled),
      .req_animation_enabled (req_animation_enabled),
      .req_strip_id          (req_strip_id),
      .rsp_strobe            (rsp_strobe),
      .rsp_strip_tag         (rsp_strip_tag),
      .rsp_led_index         (rsp_led_index),
      .rsp_red               (rsp_red),
      .rsp_green             (rsp_green),
      .rsp_blue              (rsp_blue),
      .rsp_last_led          (rsp_last_led),
      .csr_we                (csr_we),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A run that outlasts the limit has lost a request or a result.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CLOCK_LIMIT) begin
         $display("timeout after %0d cycles, %0d LED results outstanding",
                  cycle_count, pending_leds.size());
         $display("led_bar_graph_renderer regression: fail");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("LED %0d %s got %0h, want %0h",
                                oldest_led.index, name, got, want));
   endtask

   // Dim one channel to the partial brightness of the boundary LED.
   function automatic logic [CHAN_W-1:0] dim_channel(input int unsigned chan,
                                                     input int unsigned part);
      return CHAN_W'((chan * (part + 1)) >> 8);
   endfunction

   // Work out the colour of every LED on the strip for one request.
   function automatic void render_strip(input logic [SAMPLE_W-1:0] sample,
                                        input logic strip_on, input logic anim_on,
                                        input logic [TAG_W-1:0] id);
      int unsigned count, step, distance, full_leds, part, half, pos;
      logic               braking;
      logic [COLOR_W-1:0] colour;
      led_colour_type     led;
      count = cfg_led_count;
      if (count < 1) count = 1;
      if (count > MAX_LEDS) count = MAX_LEDS;
      step = SPAN / count;
      if (step == 0) step = 1;
      braking = sample < NEUTRAL_LEVEL;
      distance = braking ? (NEUTRAL_LEVEL - sample) : (sample - NEUTRAL_LEVEL);
      full_leds = distance / step;
      part = (255 * (distance % step)) / step;
      colour = braking ? cfg_brake : cfg_throttle;
      half = count / 2;
      for (int unsigned idx = 0; idx < count; idx++) begin
         case (cfg_fill_mode)
            MODE_TOP:    pos = count - 1 - idx;
            MODE_BOTTOM: pos = idx;
            default:     pos = (idx < half) ? (half - 1 - idx) : (idx - half);
         endcase
         led = '0;
         led.tag = id;
         led.index = IDX_W'(idx);
         led.last = (idx + 1 == count);
         if (strip_on && anim_on) begin
            if (pos < full_leds) begin
               {led.red, led.green, led.blue} = colour;
            end else if (pos == full_leds) begin
               led.red   = dim_channel(colour[23:16], part);
               led.green = dim_channel(colour[15:8], part);
               led.blue  = dim_channel(colour[7:0], part);
            end
         end
         pending_leds.push_back(led);
      end
   endfunction

   // Compare every LED result with the oldest outstanding one.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_leds.size() == 0) begin
            report_error($sformatf("LED result %0d arrived with nothing outstanding",
                                   rsp_led_index));
         end else begin
            oldest_led = pending_leds.pop_front();
            leds_checked++;
            check_field("strip_tag", 8'(rsp_strip_tag), 8'(oldest_led.tag));
            check_field("led_index", 8'(rsp_led_index), 8'(oldest_led.index));
            check_field("red", rsp_red, oldest_led.red);
            check_field("green", rsp_green, oldest_led.green);
            check_field("blue", rsp_blue, oldest_led.blue);
            check_field("last_led", 8'(rsp_last_led), 8'(oldest_led.last));
         end
      end
   end

   // Send one request, at times after a random pause, and hold it until busy falls again.
   task automatic send_request(input logic [SAMPLE_W-1:0] sample, input logic strip_on,
                               input logic anim_on, input logic [TAG_W-1:0] id);
      if (idle_allowed && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 90)) @(posedge clock);
      end
      start <= 1'b1;
      req_throttle_sample <= sample;
      req_strip_enabled <= strip_on;
      req_animation_enabled <= anim_on;
      req_strip_id <= id;
      do @(posedge clock); while (busy !== 1'b0);
      render_strip(sample, strip_on, anim_on, id);
      requests_sent++;
   endtask

   // Stop sending and wait until every LED result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_leds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [COLOR_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_LED_COUNT:      cfg_led_count = data[COUNT_W-1:0];
         CSR_FILL_MODE:      cfg_fill_mode = data[MODE_W-1:0];
         CSR_THROTTLE_COLOR: cfg_throttle = data;
         CSR_BRAKE_COLOR:    cfg_brake = data;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Reprogram the whole strip once the block is idle; unused upper bits carry noise.
   task automatic apply_config(input logic [COUNT_W-1:0] count, input logic [MODE_W-1:0] mode,
                               input logic [COLOR_W-1:0] thr, input logic [COLOR_W-1:0] brk);
      drain_results();
      write_register(CSR_LED_COUNT, {17'($urandom), count});
      write_register(CSR_FILL_MODE, {22'($urandom), mode});
      write_register(CSR_THROTTLE_COLOR, thr);
      write_register(CSR_BRAKE_COLOR, brk);
   endtask

   // Reset values: eight LEDs filled outward from the middle.
   task automatic test_reset_defaults();
      send_request(12'd1600, 1'b1, 1'b1, 3'd1);
      send_request(12'd1200, 1'b1, 1'b1, 3'd2);
   endtask

   // Each fill mode, with the unused code taken as middle mode.
   task automatic test_fill_modes();
      logic [MODE_W-1:0] modes[4] = '{MODE_TOP, MODE_BOTTOM, MODE_MIDDLE, MODE_UNUSED};
      foreach (modes[m]) begin
         apply_config(7'd10, modes[m], 24'h3C9AF0, 24'hE0147B);
         send_request(12'd1730, 1'b1, 1'b1, 3'(m));
         send_request(12'd1310, 1'b1, 1'b1, 3'(m + 4));
      end
   endtask

   // A count of zero acts as one and counts above the strip limit are clamped.
   task automatic test_count_limits();
      logic [COUNT_W-1:0] counts[5] = '{7'd0, 7'd1, 7'd64, 7'd65, 7'd127};
      foreach (counts[c]) begin
         apply_config(counts[c], MODE_BOTTOM, 24'hFFFFFF, 24'h000000);
         send_request(12'd1777, 1'b1, 1'b1, 3'd7);
      end
   endtask

   // Either enable low gives a black strip that is still sent out in full.
   task automatic test_disabled();
      apply_config(7'd8, MODE_MIDDLE, 24'h00FF00, 24'hFF0000);
      send_request(12'd1800, 1'b0, 1'b1, 3'd3);
      send_request(12'd1800, 1'b1, 1'b0, 3'd4);
      send_request(12'd200, 1'b0, 1'b0, 3'd5);
   endtask

   // Neutral, just either side of it, full scale and far past it in both directions.
   task automatic test_sample_extremes();
      logic [SAMPLE_W-1:0] samples[7] =
         '{12'd0, 12'd4095, 12'd1499, 12'd1500, 12'd1501, 12'd1000, 12'd2000};
      apply_config(7'd16, MODE_TOP, 24'hFFFFFF, 24'hFF00FF);
      foreach (samples[s]) send_request(samples[s], 1'b1, 1'b1, 3'(s));
   endtask

   // Random phases, each under a fresh configuration; one phase never pauses.
   task automatic test_random();
      logic [COUNT_W-1:0]  count;
      logic [SAMPLE_W-1:0] sample;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case ($urandom_range(9))
            0:       count = 7'($urandom_range(65, 127));
            1:       count = 7'd0;
            2:       count = 7'd64;
            default: count = 7'($urandom_range(1, 64));
         endcase
         apply_config(count, MODE_W'($urandom_range(3)), 24'($urandom), 24'($urandom));
         idle_allowed = (phase != 4);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // Mostly samples inside the bar's range, with some full-range and edge values.
            case ($urandom_range(9))
               6, 7:    sample = 12'($urandom);
               8:       sample = 12'($urandom_range(1490, 1510));
               9:       sample = $urandom_range(1) ? 12'd4095 : 12'd0;
               default: sample = 12'($urandom_range(900, 2100));
            endcase
            send_request(sample, $urandom_range(99) < 88, $urandom_range(99) < 88,
                         3'($urandom));
         end
      end
      idle_allowed = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_fill_modes();
      test_count_limits();
      test_disabled();
      test_sample_extremes();
      test_random();
      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d requests and checked %0d LED colours over all fill modes,",
               requests_sent, leds_checked);
      $display("strip lengths from clamped zero to the limit, and both enables.");
      if (error_count == 0)
         $display("led_bar_graph_renderer regression: pass");
      else
         $display("led_bar_graph_renderer regression: fail");
      $finish;
   end

endmodule
